// ----- sv/rptp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptp_pkg
// Shared types, codes and constants for the relay peer table policy block.
// ----------------------------------------------------------------------------
package rptp_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = 64;
  localparam int PORT_W  = 16;
  localparam int FAM_W   = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 8;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 152;

  localparam logic [CFG_W-1:0] RESP_TIMEOUT_RST  = 16'd10;
  localparam logic [CFG_W-1:0] MAX_UNANSWERED_RST = 16'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_RESPONSE_TIMEOUT = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_UNANSWERED   = 8'd1;

  // Opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_ADD = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MISS    = 2'd0,
    ST_HIT     = 2'd1,
    ST_REFRESH = 2'd2,
    ST_STORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot;     // already reduced modulo the table size
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [PORT_W-1:0] port;
    logic [FAM_W-1:0]  family;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [PORT_W-1:0] port;
    logic [FAM_W-1:0]  family;
    logic [CNT_W-1:0]  miss;
    logic [TIME_W-1:0] last_used;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [PORT_W-1:0] port;
    logic [FAM_W-1:0]  family;
  } result_t;

  // Handshake between the front queue and the back engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ----- sv/rptp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptp_front
// Accepts input transactions, unpacks and classifies them, and holds them in
// a two-entry queue for the back engine.
// ----------------------------------------------------------------------------
module rptp_front
  import rptp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [0:0]           in_tuser,
  output queue_out_t           q_out,
  input  logic                 q_pop
);

  item_t       buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       item_in;
  logic [SLOT_W:0] slot_red;

  // Reduce the random slot into the table range by repeated subtraction;
  // three steps cover tables of two or more entries.
  always_comb begin
    slot_red = {1'b0, in_tdata[SLOT_W-1:0]};
    for (int k = 0; k < 3; k++) begin
      if (int'(slot_red) >= TABLE_ENTRIES) begin
        slot_red = slot_red - (SLOT_W+1)'(TABLE_ENTRIES);
      end
    end
  end

  always_comb begin
    item_in.opcode    = in_tuser[0];
    item_in.slot      = slot_red[SLOT_W-1:0];
    item_in.now       = in_tdata[34:3];
    item_in.addr_high = in_tdata[98:35];
    item_in.addr_low  = in_tdata[162:99];
    item_in.port      = in_tdata[178:163];
    item_in.family    = in_tdata[186:179];
  end

  assign in_tready   = (count_r != 2'd2);
  assign push        = in_tvalid && in_tready;
  assign q_out.valid = (count_r != 2'd0);
  assign q_out.item  = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop && q_out.valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !(q_pop && q_out.valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop && q_out.valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ----- sv/rptp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptp_back
// Peer table engine: probes the table for get transactions, walks it for add
// transactions, updates entries and registers one result per transaction.
// ----------------------------------------------------------------------------
module rptp_back
  import rptp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] response_timeout,
  input  logic [CFG_W-1:0] max_unanswered,
  input  queue_out_t       q_in,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_result
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROBE = 5'b00010,
    S_WALK  = 5'b00100,
    S_STORE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data_r;
  logic             rd_valid_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           ent;

  item_t             cur_r, cur_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cand_r, cand_nxt;
  logic [CNT_W-1:0]  cand_miss_r, cand_miss_nxt;
  logic [TIME_W-1:0] cand_time_r, cand_time_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0] slot_idx;
  logic             under;
  logic             timed_out;
  logic             hit;
  logic             match;
  logic             take;

  // Entries that were never stored read as all zero.
  assign ent      = rd_valid_r ? rd_data_r : '0;
  assign slot_idx = IDX_W'(cur_r.slot);

  assign under     = ent.miss < max_unanswered;
  assign timed_out = ({1'b0, ent.last_used} + {17'd0, response_timeout})
                     <= {1'b0, cur_r.now};
  assign hit       = rd_valid_r && (under || !timed_out);
  assign match     = rd_valid_r && (cur_r.port != '0) && (ent.port == cur_r.port) &&
                     (ent.addr_high == cur_r.addr_high) &&
                     (ent.addr_low == cur_r.addr_low) &&
                     (ent.family == cur_r.family);
  assign take      = !rd_valid_r || ((ent.miss != '0) &&
                     ((cand_miss_r == '0) || (ent.last_used < cand_time_r)));

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    cand_nxt      = cand_r;
    cand_miss_nxt = cand_miss_r;
    cand_time_nxt = cand_time_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = slot_idx;
    wr_en         = 1'b0;
    wr_addr       = slot_idx;
    wr_data       = ent;

    case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_in.item;
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(q_in.item.slot);
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (cur_r.opcode == OP_GET) begin
          res_nxt = '0;
          if (hit) begin
            res_nxt.status    = ST_HIT;
            res_nxt.addr_high = ent.addr_high;
            res_nxt.addr_low  = ent.addr_low;
            res_nxt.port      = ent.port;
            res_nxt.family    = ent.family;
            wr_en             = 1'b1;
            wr_data.miss      = ent.miss + CNT_W'(1);
            if (under) begin
              wr_data.last_used = cur_r.now;
            end
          end else begin
            res_nxt.status = ST_MISS;
          end
          state_nxt = S_RESP;
        end else begin
          // The probed slot is the first victim candidate.
          cand_nxt      = slot_idx;
          cand_miss_nxt = ent.miss;
          cand_time_nxt = ent.last_used;
          idx_nxt       = '0;
          rd_en         = 1'b1;
          rd_addr       = '0;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (match) begin
          wr_en          = 1'b1;
          wr_addr        = idx_r;
          wr_data.miss   = '0;
          res_nxt        = '0;
          res_nxt.status = ST_REFRESH;
          state_nxt      = S_RESP;
        end else begin
          if (take) begin
            cand_nxt      = idx_r;
            cand_miss_nxt = ent.miss;
            cand_time_nxt = ent.last_used;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_STORE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      S_STORE: begin
        wr_en             = 1'b1;
        wr_addr           = cand_r;
        wr_data.addr_high = cur_r.addr_high;
        wr_data.addr_low  = cur_r.addr_low;
        wr_data.port      = cur_r.port;
        wr_data.family    = cur_r.family;
        wr_data.miss      = '0;
        wr_data.last_used = cand_time_r;
        valid_nxt[cand_r] = 1'b1;
        res_nxt           = '0;
        res_nxt.status    = ST_STORED;
        state_nxt         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    cand_r      <= cand_nxt;
    cand_miss_r <= cand_miss_nxt;
    cand_time_r <= cand_time_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  // Table storage: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef ASSERT_OFF
  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) >= $past($countones(valid_r)))
    else $error("peer table lost a valid entry");

  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && $past(state_r == S_WALK)) |-> (idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("table walk skipped or repeated an entry");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |=> valid_r[$past(cand_r)])
    else $error("stored entry not marked valid");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_RESP))
    else $error("result presented outside the response step");
`endif

endmodule

// ----- sv/relay_peer_table_policy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_peer_table_policy
// Relay peer table: get transactions probe a random entry and return its peer
// under the miss-count and timeout rules; add transactions refresh a matching
// peer or store it over a victim entry.
//
// Channel  Dir  Handshake          Payload
// in_      in   tvalid / tready    tuser: opcode; tdata: slot, time, peer
// out_     out  tvalid / tready    tuser: status; tdata: chosen peer
// cfg_     in   valid / ready      index, data (timeout, max unanswered)
//
// A get transaction goes from the queue head through the probe and response
// states to the output register; an add also walks the table through its
// single read port, one entry per cycle; a match ends the walk early, else
// the peer is stored over the victim entry.
// The front queue holds two transactions, so up to two inputs are accepted
// while the engine works or while a result waits on out_tready.
// Reset is synchronous and clears the valid marks; no clearing pass is needed.
// Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
module relay_peer_table_policy
  import rptp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] random_slot, [34:3] now_seconds, [98:35] addr_high,
  // [162:99] addr_low, [178:163] port_number, [186:179] addr_family, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [0:0]            in_tuser,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] peer_addr_high, [127:64] peer_addr_low, [143:128] peer_port,
  // [151:144] peer_family
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]            out_tuser,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [CFG_W-1:0] resp_timeout_r, resp_timeout_nxt;
  logic [CFG_W-1:0] max_unans_r, max_unans_nxt;
  queue_out_t       q_head;
  logic             q_pop;
  result_t          result;

  assign cfg_ready = 1'b1;

  always_comb begin
    resp_timeout_nxt = resp_timeout_r;
    max_unans_nxt    = max_unans_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RESPONSE_TIMEOUT: resp_timeout_nxt = cfg_data;
        CFG_MAX_UNANSWERED:   max_unans_nxt    = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_timeout_r <= RESP_TIMEOUT_RST;
      max_unans_r    <= MAX_UNANSWERED_RST;
    end else begin
      resp_timeout_r <= resp_timeout_nxt;
      max_unans_r    <= max_unans_nxt;
    end
  end

  rptp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_out     (q_head),
    .q_pop     (q_pop)
  );

  rptp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .response_timeout (resp_timeout_r),
    .max_unanswered   (max_unans_r),
    .q_in             (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_result       (result)
  );

  assign out_tuser = result.status;
  assign out_tdata = {result.family, result.port, result.addr_low, result.addr_high};

endmodule
